FILE: design/pp5d_pkg.sv
// Package for the packed 5-bit palette decoder.
// Holds shared constants, codes and payload types; no dependencies.
`default_nettype none

package pp5d_pkg;

    localparam int PALETTE_DEPTH = 32;
    localparam int INDEX_W       = 5;
    localparam int COLOR_W       = 32;
    localparam int SIZE_W        = 6;
    localparam int BUF_W         = 12;
    localparam int HELD_W        = 3;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    localparam logic CFG_PALETTE_ENTRIES = 1'b0;
    localparam logic CFG_FALLBACK_INDEX  = 1'b1;

    localparam logic [SIZE_W-1:0]  PALETTE_ENTRIES_RST = 6'd15;
    localparam logic [INDEX_W-1:0] FALLBACK_INDEX_RST  = 5'd14;

    typedef struct packed {
        logic               last;
        logic [INDEX_W-1:0] index;
    } pend_t;

    typedef struct packed {
        logic               last;
        logic               invalid;
        logic [INDEX_W-1:0] index;
        logic [COLOR_W-1:0] color;
    } pix_t;

endpackage

`default_nettype wire

FILE: design/pp5d_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No package dependencies.
`default_nettype none

module pp5d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: design/pp5d_unpack.sv
// Bit buffer and pending index slots: splits each pixel byte into one or two indices.
// Depends on pp5d_pkg.
`default_nettype none

module pp5d_unpack (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic          action,
    input  wire logic          start_of_image,
    input  wire logic [7:0]    data_byte,
    input  wire logic          issue,
    output pp5d_pkg::pend_t    head,
    output logic [1:0]         pend_cnt
);

    logic [pp5d_pkg::BUF_W-1:0]  bit_buffer_reg, bit_buffer_next;
    logic [pp5d_pkg::HELD_W-1:0] bits_held_reg, bits_held_next;
    logic [1:0]                  cnt_reg, cnt_next;
    pp5d_pkg::pend_t             pend0_reg, pend0_next;
    pp5d_pkg::pend_t             pend1_reg, pend1_next;

    logic [pp5d_pkg::BUF_W-1:0]  buf0;
    logic [pp5d_pkg::HELD_W-1:0] held0;
    logic [pp5d_pkg::BUF_W-1:0]  new_buf;
    logic [3:0]                  held_sum;
    logic [3:0]                  sh0;
    logic [3:0]                  sh1;
    logic                        two;
    logic [pp5d_pkg::INDEX_W-1:0] idx0;
    logic [pp5d_pkg::INDEX_W-1:0] idx1;

    always_comb
    begin
        buf0     = start_of_image ? '0 : bit_buffer_reg;
        held0    = start_of_image ? '0 : bits_held_reg;
        new_buf  = {buf0[3:0], data_byte};
        held_sum = 4'({1'b0, held0} + 4'd8);
        two      = held_sum >= 4'd10;
        sh0      = held_sum - 4'd5;
        sh1      = held_sum - 4'd10;
        idx0     = pp5d_pkg::INDEX_W'(new_buf >> sh0);
        idx1     = pp5d_pkg::INDEX_W'(new_buf >> sh1);

        bit_buffer_next = bit_buffer_reg;
        bits_held_next  = bits_held_reg;
        cnt_next        = cnt_reg;
        pend0_next      = pend0_reg;
        pend1_next      = pend1_reg;

        if (issue)
        begin
            pend0_next = pend1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end

        if (accept && action == pp5d_pkg::ACT_PIXEL)
        begin
            bit_buffer_next  = new_buf;
            bits_held_next   = two ? pp5d_pkg::HELD_W'(sh1) : pp5d_pkg::HELD_W'(sh0);
            pend0_next.index = idx0;
            pend0_next.last  = !two;
            pend1_next.index = idx1;
            pend1_next.last  = 1'b1;
            cnt_next         = two ? 2'd2 : 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_buffer_reg <= '0;
            bits_held_reg  <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            bit_buffer_reg <= bit_buffer_next;
            bits_held_reg  <= bits_held_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend0_reg <= pend0_next;
        pend1_reg <= pend1_next;
    end

    assign head     = pend0_reg;
    assign pend_cnt = cnt_reg;

endmodule

`default_nettype wire

FILE: design/pp5d_outq.sv
// Two-entry result queue between the palette read and the output channel.
// Depends on pp5d_pkg.
`default_nettype none

module pp5d_outq (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire pp5d_pkg::pix_t push_data,
    input  wire logic          pop,
    output pp5d_pkg::pix_t     head,
    output logic [1:0]         occ
);

    pp5d_pkg::pix_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     occ_reg, occ_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        occ_next    = occ_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            occ_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            occ_reg    <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head = slot_reg[rd_ptr_reg];
    assign occ  = occ_reg;

endmodule

`default_nettype wire

FILE: design/packed_5bit_palette_decoder.sv
// Top level of the packed 5-bit palette decoder: config registers, palette read issue.
// Depends on pp5d_pkg, pp5d_ram, pp5d_unpack and pp5d_outq.
//
// channel   direction  handshake              payload
// s_*       in         s_tvalid / s_tready    tdata: byte, entry; tuser: action, start
// m_*       out        m_tvalid / m_tready    tdata: color, index; tuser: invalid; tlast
// cfg_*     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A byte yields one or two pixels; the palette RAM read port issues one lookup per cycle
// while the result queue has room. A pixel passes the pending slot, the registered read
// and the result queue. Loads write the RAM on their transfer. Reset clears the bit buffer
// and counters and loads the config register defaults; the palette is undefined until loaded.
// A stall on m_tready fills the two-entry result queue, then holds issue and s_tready.
`default_nettype none

module packed_5bit_palette_decoder #(
    parameter int PALETTE_DEPTH = pp5d_pkg::PALETTE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] data_byte, [12:8] entry_index, [20:13] entry_alpha, [28:21] entry_red,
    // [36:29] entry_green, [44:37] entry_blue, [47:45] zero
    input  wire logic [47:0] s_tdata,
    // [0] action, [1] start_of_image
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] pixel_alpha, [15:8] pixel_red, [23:16] pixel_green, [31:24] pixel_blue,
    // [36:32] color_index, [39:37] zero
    output logic [39:0]      m_tdata,
    // [0] index_invalid
    output logic             m_tuser,
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [5:0]  cfg_data
);

    localparam int AW = PALETTE_DEPTH > 1 ? $clog2(PALETTE_DEPTH) : 1;
    localparam logic [pp5d_pkg::SIZE_W-1:0] DepthSize = pp5d_pkg::SIZE_W'(PALETTE_DEPTH);

    logic [pp5d_pkg::SIZE_W-1:0]  palette_entries_reg, palette_entries_next;
    logic [pp5d_pkg::INDEX_W-1:0] fallback_index_reg, fallback_index_next;

    logic                         rd_valid_reg;
    pp5d_pkg::pend_t              rd_pend_reg;
    logic                         rd_bad_reg;
    logic                         rd_zero_reg;

    logic                         s_accept;
    logic                         action;
    logic                         issue;
    logic                         pop;
    logic [1:0]                   pend_cnt;
    logic [1:0]                   occ;
    pp5d_pkg::pend_t              head;
    pp5d_pkg::pix_t               push_data;
    pp5d_pkg::pix_t               out_pix;
    logic [pp5d_pkg::SIZE_W-1:0]  size;
    logic                         bad;
    logic [pp5d_pkg::INDEX_W-1:0] sel;
    logic                         sel_out;
    logic                         we;
    logic [pp5d_pkg::COLOR_W-1:0] wdata;
    logic [pp5d_pkg::COLOR_W-1:0] rdata;

    assign action   = s_tuser[0];
    assign pop      = m_tvalid && m_tready;
    assign issue    = pend_cnt != 2'd0
                   && ({1'b0, occ} + {2'b0, rd_valid_reg}) <= (3'd1 + {2'b0, pop});
    assign s_tready = pend_cnt == 2'd0 || (pend_cnt == 2'd1 && issue);
    assign s_accept = s_tvalid && s_tready;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        palette_entries_next = palette_entries_reg;
        fallback_index_next  = fallback_index_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                pp5d_pkg::CFG_PALETTE_ENTRIES: palette_entries_next = cfg_data;
                pp5d_pkg::CFG_FALLBACK_INDEX:  fallback_index_next  = cfg_data[4:0];
                default:                       palette_entries_next = palette_entries_reg;
            endcase
        end
    end

    always_comb
    begin
        size    = palette_entries_reg > DepthSize ? DepthSize : palette_entries_reg;
        bad     = {1'b0, head.index} >= size;
        sel     = bad ? fallback_index_reg : head.index;
        sel_out = {1'b0, sel} >= DepthSize;
        we      = s_accept && action == pp5d_pkg::ACT_LOAD
               && {1'b0, s_tdata[12:8]} < DepthSize;
        wdata   = {s_tdata[20:13], s_tdata[28:21], s_tdata[36:29], s_tdata[44:37]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_entries_reg <= pp5d_pkg::PALETTE_ENTRIES_RST;
            fallback_index_reg  <= pp5d_pkg::FALLBACK_INDEX_RST;
            rd_valid_reg        <= 1'b0;
        end
        else
        begin
            palette_entries_reg <= palette_entries_next;
            fallback_index_reg  <= fallback_index_next;
            rd_valid_reg        <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_pend_reg <= head;
            rd_bad_reg  <= bad;
            rd_zero_reg <= sel_out;
        end
    end

    pp5d_ram #(
        .WIDTH (pp5d_pkg::COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (we),
        .waddr (s_tdata[8 +: AW]),
        .wdata (wdata),
        .raddr (sel[AW-1:0]),
        .rdata (rdata)
    );

    pp5d_unpack u_unpack (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (s_accept),
        .action         (action),
        .start_of_image (s_tuser[1]),
        .data_byte      (s_tdata[7:0]),
        .issue          (issue),
        .head           (head),
        .pend_cnt       (pend_cnt)
    );

    always_comb
    begin
        push_data.color   = rd_zero_reg ? '0 : rdata;
        push_data.index   = rd_pend_reg.index;
        push_data.invalid = rd_bad_reg;
        push_data.last    = rd_pend_reg.last;
    end

    pp5d_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rd_valid_reg),
        .push_data (push_data),
        .pop       (pop),
        .head      (out_pix),
        .occ       (occ)
    );

    assign m_tvalid = occ != 2'd0;
    assign m_tdata  = {3'b000, out_pix.index, out_pix.color[7:0], out_pix.color[15:8],
                       out_pix.color[23:16], out_pix.color[31:24]};
    assign m_tuser  = out_pix.invalid;
    assign m_tlast  = out_pix.last;

endmodule

`default_nettype wire

FILE: dv/packed_5bit_palette_decoder_test.sv
// Self-checking testbench for packed_5bit_palette_decoder: palette loads, packed pixel bytes,
// register sweeps and output back-pressure, checked against an in-bench decoder model.
// Depends on pp5d_pkg and the decoder RTL only.
module packed_5bit_palette_decoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic        action;
        logic [7:0]  data_byte;
        logic        sof;
        logic [4:0]  slot;
        logic [31:0] argb;
    } stream_item_t;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [4:0] index;
        logic       invalid;
        logic       last;
    } pixel_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [5:0]  cfg_data;

    logic [31:0] palette_argb [pp5d_pkg::PALETTE_DEPTH];
    logic [5:0]  active_entries = pp5d_pkg::PALETTE_ENTRIES_RST;
    logic [4:0]  fallback_slot  = pp5d_pkg::FALLBACK_INDEX_RST;
    logic [11:0] bit_buffer     = '0;
    logic [3:0]  bits_held      = '0;
    pixel_t      pixel_queue [$];

    int  byte_count     = 0;
    int  load_count     = 0;
    int  cfg_count      = 0;
    int  pixel_count    = 0;
    int  fallback_count = 0;
    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  burst_left     = 0;
    bit  hold_off_req   = 1'b0;

    packed_5bit_palette_decoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d pixels still expected",
                 cycle_count, pixel_queue.size());
        $display("packed_5bit_palette_decoder_test failed");
        $finish;
    end

    // receiver: stall modes change at random; a requested hold-off parks it for a long stretch
    initial
    begin
        int run_left;
        int mode;
        run_left = 0;
        mode = 0;
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            if (run_left == 0)
            begin
                run_left = $urandom_range(20, 120);
                mode = $urandom_range(0, 2);
            end
            run_left--;
            case (mode)
                0: m_tready = 1'b1;
                1: m_tready = 1'($urandom_range(0, 1));
                default: m_tready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic predict_transfer(input stream_item_t it);
        logic [3:0]  held;
        logic [5:0]  size;
        logic [4:0]  idx [2];
        logic [31:0] color;
        pixel_t      px;
        int          n;
        if (it.action == pp5d_pkg::ACT_LOAD)
        begin
            palette_argb[it.slot] = it.argb;
            load_count++;
            return;
        end
        byte_count++;
        if (it.sof)
        begin
            bit_buffer = '0;
            bits_held = '0;
        end
        bit_buffer = {bit_buffer[3:0], it.data_byte};
        held = bits_held + 4'd8;
        if (held > 4'd12)
            held = 4'd12;
        n = 0;
        while (held >= 4'd5 && n < 2)
        begin
            idx[n] = 5'(bit_buffer >> (held - 4'd5));
            held = held - 4'd5;
            n++;
        end
        bits_held = held;
        size = (active_entries > 6'(pp5d_pkg::PALETTE_DEPTH))
             ? 6'(pp5d_pkg::PALETTE_DEPTH) : active_entries;
        for (int k = 0; k < n; k++)
        begin
            px.index = idx[k];
            px.invalid = (idx[k] >= size);
            color = palette_argb[px.invalid ? fallback_slot : idx[k]];
            {px.alpha, px.red, px.green, px.blue} = color;
            px.last = (k == n - 1);
            pixel_queue.insert(pixel_queue.size(), px);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            cfg_count++;
            if (cfg_index == pp5d_pkg::CFG_PALETTE_ENTRIES)
                active_entries = cfg_data;
            else
                fallback_slot = cfg_data[4:0];
        end
        if (rst_n && s_tvalid && s_tready)
            predict_transfer({s_tuser[0], s_tdata[7:0], s_tuser[1], s_tdata[12:8],
                              s_tdata[20:13], s_tdata[28:21], s_tdata[36:29], s_tdata[44:37]});
    end

    task automatic check_field(input string field, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            mismatch_count++;
            $display("%0t: pixel %0d %s expected %0d, got %0d",
                     $time, pixel_count, field, want_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.alpha = m_tdata[7:0];
            got.red = m_tdata[15:8];
            got.green = m_tdata[23:16];
            got.blue = m_tdata[31:24];
            got.index = m_tdata[36:32];
            got.invalid = m_tuser;
            got.last = m_tlast;
            if (pixel_queue.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected pixel, expected none, got index %0d",
                         $time, got.index);
            end
            else
            begin
                want = pixel_queue.pop_front();
                check_field("pixel_alpha", int'(want.alpha), int'(got.alpha));
                check_field("pixel_red", int'(want.red), int'(got.red));
                check_field("pixel_green", int'(want.green), int'(got.green));
                check_field("pixel_blue", int'(want.blue), int'(got.blue));
                check_field("color_index", int'(want.index), int'(got.index));
                check_field("index_invalid", int'(want.invalid), int'(got.invalid));
                check_field("last_of_byte", int'(want.last), int'(got.last));
                if (want.invalid)
                    fallback_count++;
            end
            pixel_count++;
        end
    end

    function automatic stream_item_t pixel_item(input logic [7:0] b, input logic start);
        stream_item_t it;
        it.action = pp5d_pkg::ACT_PIXEL;
        it.data_byte = b;
        it.sof = start;
        it.slot = 5'($urandom_range(0, 31));
        it.argb = $urandom();
        return it;
    endfunction

    function automatic stream_item_t load_item(input logic [4:0] slot, input logic [31:0] argb);
        stream_item_t it;
        it.action = pp5d_pkg::ACT_LOAD;
        it.data_byte = 8'($urandom_range(0, 255));
        it.sof = 1'($urandom_range(0, 1));
        it.slot = slot;
        it.argb = argb;
        return it;
    endfunction

    task automatic send_item(input stream_item_t it);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
        end
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata = {3'b000, it.argb[7:0], it.argb[15:8], it.argb[23:16], it.argb[31:24],
                   it.slot, it.data_byte};
        s_tuser = {it.sof, it.action};
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        burst_left--;
    endtask

    task automatic drain_pipeline();
        @(negedge clk);
        s_tvalid = 1'b0;
        burst_left = 0;
        while (pixel_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic idx, input logic [5:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_palette_regs(input logic [5:0] entries, input logic [5:0] fallback);
        drain_pipeline();
        write_config(pp5d_pkg::CFG_PALETTE_ENTRIES, entries);
        write_config(pp5d_pkg::CFG_FALLBACK_INDEX, fallback);
    endtask

    // mostly whole images opened by a start mark, with loads and stray start marks mixed in
    task automatic run_image_stream(input int n_items);
        int r;
        int img_left;
        img_left = 0;
        for (int i = 0; i < n_items; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                send_item(load_item(5'($urandom_range(0, 31)), $urandom()));
            else if (img_left == 0)
            begin
                img_left = 5 * $urandom_range(1, 4) - 1;
                send_item(pixel_item(8'($urandom_range(0, 255)), 1'b1));
            end
            else
            begin
                img_left--;
                send_item(pixel_item(8'($urandom_range(0, 255)), r >= 96));
            end
        end
    endtask

    task automatic test_palette_fill();
        for (int s = 0; s < pp5d_pkg::PALETTE_DEPTH; s++)
        begin
            if (s == 0)
                send_item(load_item(5'(s), 32'h0000_0000));
            else if (s == pp5d_pkg::PALETTE_DEPTH - 1)
                send_item(load_item(5'(s), 32'hFFFF_FFFF));
            else
                send_item(load_item(5'(s), $urandom()));
        end
    endtask

    task automatic test_directed_decode();
        stream_item_t seq [$];
        stream_item_t ld;
        seq.insert(seq.size(), pixel_item(8'h00, 1'b1));
        seq.insert(seq.size(), pixel_item(8'hFF, 1'b0));
        seq.insert(seq.size(), pixel_item(8'h78, 1'b1));
        seq.insert(seq.size(), pixel_item(8'h70, 1'b1));
        seq.insert(seq.size(), pixel_item(8'hFF, 1'b1));
        repeat (4) seq.insert(seq.size(), pixel_item(8'hFF, 1'b0));
        ld = load_item(pp5d_pkg::FALLBACK_INDEX_RST, 32'h1234_5678);
        ld.data_byte = 8'hFF;
        ld.sof = 1'b1;
        seq.insert(seq.size(), ld);
        seq.insert(seq.size(), pixel_item(8'hFF, 1'b0));
        seq.insert(seq.size(), pixel_item(8'hA5, 1'b0));
        seq.insert(seq.size(), pixel_item(8'h5A, 1'b1));
        seq.insert(seq.size(), pixel_item(8'hAA, 1'b0));
        seq.insert(seq.size(), pixel_item(8'h55, 1'b0));
        seq.insert(seq.size(), pixel_item(8'h00, 1'b0));
        foreach (seq[i])
            send_item(seq[i]);
    endtask

    task automatic test_register_extremes();
        logic [5:0] entries [6] = '{6'd0, 6'd32, 6'd63, 6'd1, 6'd33, 6'd20};
        logic [5:0] fallback [6] = '{6'd0, 6'd31, 6'd5, 6'd31, 6'd63, 6'd17};
        foreach (entries[i])
        begin
            set_palette_regs(entries[i], fallback[i]);
            run_image_stream(30);
        end
    endtask

    task automatic test_output_backpressure();
        hold_off_req = 1'b1;
        run_image_stream(40);
    endtask

    task automatic test_random_stream();
        for (int p = 0; p < 4; p++)
        begin
            set_palette_regs(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
            run_image_stream(70);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = pp5d_pkg::CFG_PALETTE_ENTRIES;
        cfg_data = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_palette_fill();
        test_directed_decode();
        test_register_extremes();
        test_output_backpressure();
        test_random_stream();
        drain_pipeline();

        $display("sent %0d pixel bytes and %0d palette loads over %0d register writes",
                 byte_count, load_count, cfg_count);
        $display("checked %0d pixels, %0d replaced by the fallback entry, %0d mismatches",
                 pixel_count, fallback_count, mismatch_count);
        if (mismatch_count == 0)
            $display("packed_5bit_palette_decoder_test passed");
        else
            $display("packed_5bit_palette_decoder_test failed");
        $finish;
    end

endmodule
